// ----- rtl/ssip_pkg.sv -----
`timescale 1ns / 1ps

package ssip_pkg;

    localparam int CAPACITY   = 16;
    localparam int KEY_BITS   = 32;
    localparam int COUNT_BITS = 5;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_POP    = 1'b1;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_POPPED    = 3'd3,
        ST_UNDERFLOW = 3'd4
    } status_t;

    typedef struct packed {
        logic                action;
        logic [KEY_BITS-1:0] key;
    } req_t;

    typedef struct packed {
        logic [2:0]            status;
        logic                  front_valid;
        logic [KEY_BITS-1:0]   front_key;
        logic [COUNT_BITS-1:0] entry_count;
    } rsp_t;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic                insert;
        logic                pop;
        logic                descending;
        logic [KEY_BITS-1:0] key;
    } cell_ctrl_t;

endpackage

// ----- rtl/ssip_cell.sv -----
`timescale 1ns / 1ps

module ssip_cell
(
    input  logic                          clk,
    input  ssip_pkg::cell_ctrl_t          ctrl,
    input  logic                          occupied,
    input  logic [ssip_pkg::KEY_BITS-1:0] left_key,
    input  logic [ssip_pkg::KEY_BITS-1:0] right_key,
    input  logic                          before_in,
    output logic                          before_out,
    output logic                          stop,
    output logic                          dup,
    output logic [ssip_pkg::KEY_BITS-1:0] value
);

    logic [ssip_pkg::KEY_BITS-1:0] value_reg;
    logic [ssip_pkg::KEY_BITS-1:0] value_next;
    logic                          precedes;

    // stored entry belongs strictly ahead of the incoming key
    assign precedes   = ctrl.descending ? (value_reg > ctrl.key) : (value_reg < ctrl.key);
    assign stop       = !occupied || !precedes;
    assign before_out = before_in || stop;
    assign dup        = stop && !before_in && occupied && (value_reg == ctrl.key);
    assign value      = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.insert)
        begin
            if (before_in)
            begin
                value_next = left_key;      // shift back behind the insert point
            end
            else if (stop)
            begin
                value_next = ctrl.key;      // this is the insert point
            end
        end
        else if (ctrl.pop)
        begin
            value_next = right_key;         // advance toward the front
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// ----- rtl/sorted_set_insert_pop.sv -----
// A request's response is registered and shows on out_valid the cycle after the request is
// taken. Throughput: one request per cycle, set by the single
// compare-and-shift pass through the row of cells; a response held by out_stall holds
// off the next request. Reset clears the entry count, the order bit (ascending) and the
// output valid; stored keys are not cleared and are read only below the entry count.
`timescale 1ns / 1ps

module sorted_set_insert_pop
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_write,
    input  logic           cfg_data,
    input  logic           in_valid,
    output logic           in_stall,
    input  ssip_pkg::req_t in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output ssip_pkg::rsp_t out_data
);

    localparam int N  = ssip_pkg::CAPACITY;
    localparam int KB = ssip_pkg::KEY_BITS;
    localparam int CB = ssip_pkg::COUNT_BITS;

    logic                 descending_reg;
    logic [CB-1:0]        count_reg;
    logic [CB-1:0]        count_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    ssip_pkg::rsp_t       out_data_reg;
    ssip_pkg::rsp_t       out_data_next;

    logic                 accept;
    logic                 is_pop;
    logic                 full;
    logic                 empty;
    logic                 any_dup;
    logic                 ins_ok;
    logic                 pop_ok;
    logic [KB-1:0]        front_next;
    ssip_pkg::status_t    status;
    ssip_pkg::cell_ctrl_t ctrl;

    logic [N-1:0]         occupied;
    logic [N:0]           past_point;
    logic [N-1:0]         stop;
    logic [N-1:0]         dup;
    logic [N-1:0]         first;
    logic [KB-1:0]        keys [N];

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign is_pop   = (in_data.action == ssip_pkg::ACT_POP);
    assign full     = (count_reg == CB'(N));
    assign empty    = (count_reg == '0);
    assign any_dup  = |dup;
    assign ins_ok   = accept && !is_pop && !any_dup && !full;
    assign pop_ok   = accept && is_pop && !empty;

    assign ctrl.insert     = ins_ok;
    assign ctrl.pop        = pop_ok;
    assign ctrl.descending = descending_reg;
    assign ctrl.key        = in_data.key;

    assign past_point[0] = 1'b0;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        logic [KB-1:0] left_key;
        logic [KB-1:0] right_key;

        assign occupied[i] = (count_reg > CB'(i));
        assign first[i]    = stop[i] && !past_point[i];

        if (i == 0)
        begin : g_head
            assign left_key = '0;
        end
        else
        begin : g_mid
            assign left_key = keys[i-1];
        end

        if (i == N - 1)
        begin : g_tail
            assign right_key = '0;
        end
        else
        begin : g_body
            assign right_key = keys[i+1];
        end

        ssip_cell u_cell
        (
            .clk        (clk),
            .ctrl       (ctrl),
            .occupied   (occupied[i]),
            .left_key   (left_key),
            .right_key  (right_key),
            .before_in  (past_point[i]),
            .before_out (past_point[i+1]),
            .stop       (stop[i]),
            .dup        (dup[i]),
            .value      (keys[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        status     = ssip_pkg::ST_INSERTED;
        if (is_pop)
        begin
            if (empty)
            begin
                status = ssip_pkg::ST_UNDERFLOW;
            end
            else
            begin
                status     = ssip_pkg::ST_POPPED;
                count_next = count_reg - CB'(1);
            end
        end
        else if (any_dup)
        begin
            status = ssip_pkg::ST_DUPLICATE;
        end
        else if (full)
        begin
            status = ssip_pkg::ST_FULL;
        end
        else
        begin
            count_next = count_reg + CB'(1);
        end

        if (ins_ok && stop[0])
        begin
            front_next = in_data.key;
        end
        else if (pop_ok)
        begin
            front_next = keys[1];
        end
        else
        begin
            front_next = keys[0];
        end

        out_data_next.status      = status;
        out_data_next.front_valid = (count_next != '0);
        out_data_next.front_key   = (count_next != '0) ? front_next : '0;
        out_data_next.entry_count = count_next;

        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            descending_reg <= 1'b0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                descending_reg <= cfg_data;
            end
            if (accept)
            begin
                count_reg <= count_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CB'(N))
        else $error("entry count above capacity");

    a_single_insert_point: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(first))
        else $error("more than one insert point in the cell row");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ins_ok |=> count_reg == $past(count_reg) + CB'(1))
        else $error("accepted insert did not grow the count");

    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        pop_ok |=> count_reg == $past(count_reg) - CB'(1))
        else $error("accepted pop did not shrink the count");

    a_front_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.front_valid == (out_data_reg.entry_count != '0)))
        else $error("front valid flag disagrees with entry count");

endmodule

// ----- tb/sorted_set_checker.sv -----
`timescale 1ns / 1ps

module sorted_set_checker
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_write,
    input  logic           cfg_data,
    input  logic           in_valid,
    input  logic           in_stall,
    input  ssip_pkg::req_t in_data,
    input  logic           out_valid,
    input  logic           out_stall,
    input  ssip_pkg::rsp_t out_data,
    output int             mismatches,
    output int             pending,
    output int             checked,
    output int             dup_seen,
    output int             full_seen,
    output int             underflow_seen
);

    logic [ssip_pkg::KEY_BITS-1:0] held_keys [ssip_pkg::CAPACITY];
    int                            held_count;
    logic                          order_desc;
    ssip_pkg::rsp_t                expected_q [$];
    ssip_pkg::rsp_t                predicted;

    // true when a sits strictly ahead of b in the current order
    function automatic logic ahead(input logic [ssip_pkg::KEY_BITS-1:0] a,
                                   input logic [ssip_pkg::KEY_BITS-1:0] b);
        return order_desc ? (a > b) : (a < b);
    endfunction

    task automatic apply_request(input ssip_pkg::req_t rq, output ssip_pkg::rsp_t rs);
        int                pos;
        ssip_pkg::status_t st;
        if (rq.action == ssip_pkg::ACT_INSERT)
        begin
            pos = 0;
            while (pos < held_count && ahead(held_keys[pos], rq.key))
                pos++;
            // duplicate check comes first, even when full
            if (pos < held_count && !ahead(rq.key, held_keys[pos]))
                st = ssip_pkg::ST_DUPLICATE;
            else if (held_count >= ssip_pkg::CAPACITY)
                st = ssip_pkg::ST_FULL;
            else
            begin
                for (int i = held_count; i > pos; i--)
                    held_keys[i] = held_keys[i - 1];
                held_keys[pos] = rq.key;
                held_count++;
                st = ssip_pkg::ST_INSERTED;
            end
        end
        else if (held_count == 0)
            st = ssip_pkg::ST_UNDERFLOW;
        else
        begin
            for (int i = 1; i < held_count; i++)
                held_keys[i - 1] = held_keys[i];
            held_count--;
            st = ssip_pkg::ST_POPPED;
        end
        rs.status      = st;
        rs.front_valid = (held_count > 0);
        rs.front_key   = (held_count > 0) ? held_keys[0] : '0;
        rs.entry_count = ssip_pkg::COUNT_BITS'(held_count);
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] sorted set mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_response(input ssip_pkg::rsp_t got);
        ssip_pkg::rsp_t want;
        if (expected_q.size() == 0)
        begin
            report_mismatch("response with no request outstanding");
            return;
        end
        want = expected_q[0];
        expected_q.delete(0);
        checked++;
        case (want.status)
            ssip_pkg::ST_DUPLICATE: dup_seen++;
            ssip_pkg::ST_FULL:      full_seen++;
            ssip_pkg::ST_UNDERFLOW: underflow_seen++;
            default: ;
        endcase
        if (got.status !== want.status)
            report_mismatch($sformatf("response %0d status got %0d want %0d",
                checked, got.status, want.status));
        if (got.front_valid !== want.front_valid)
            report_mismatch($sformatf("response %0d front_valid got %0b want %0b",
                checked, got.front_valid, want.front_valid));
        if (got.front_key !== want.front_key)
            report_mismatch($sformatf("response %0d front_key got %h want %h",
                checked, got.front_key, want.front_key));
        if (got.entry_count !== want.entry_count)
            report_mismatch($sformatf("response %0d entry_count got %0d want %0d",
                checked, got.entry_count, want.entry_count));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count = 0;
            order_desc = 1'b0;
            expected_q.delete();
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_response(out_data);
            // a request taken at this edge still sees the old order
            if (in_valid && !in_stall)
            begin
                apply_request(in_data, predicted);
                expected_q.push_back(predicted);
            end
            if (cfg_write)
                order_desc = cfg_data;
            pending <= expected_q.size();
        end
    end

endmodule

// ----- tb/sorted_set_insert_pop_test.sv -----
`timescale 1ns / 1ps

module sorted_set_insert_pop_test;

    localparam int CYCLE_LIMIT = 200000;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           cfg_write = 1'b0;
    logic           cfg_data  = 1'b0;
    logic           in_valid  = 1'b0;
    logic           in_stall;
    ssip_pkg::req_t in_data   = '0;
    logic           out_valid;
    logic           out_stall = 1'b0;
    ssip_pkg::rsp_t out_data;

    int mismatches;
    int pending;
    int checked;
    int dup_seen;
    int full_seen;
    int underflow_seen;

    int             gap_pct   = 0;
    int             stall_pct = 0;
    int             cycles    = 0;
    ssip_pkg::req_t req_q [$];

    sorted_set_insert_pop dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    sorted_set_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data),
        .mismatches     (mismatches),
        .pending        (pending),
        .checked        (checked),
        .dup_seen       (dup_seen),
        .full_seen      (full_seen),
        .underflow_seen (underflow_seen)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses outstanding", cycles, pending);
            $display("sorted_set_insert_pop verification failed");
            $finish;
        end
    end

    function automatic ssip_pkg::req_t make_request(input logic act,
                                                    input logic [ssip_pkg::KEY_BITS-1:0] k);
        ssip_pkg::req_t rq;
        rq.action = act;
        rq.key    = k;
        return rq;
    endfunction

    function automatic ssip_pkg::req_t random_request(input int insert_pct);
        ssip_pkg::req_t rq;
        int             pick;
        pick      = $urandom_range(99);
        rq.action = ($urandom_range(99) < insert_pct) ? ssip_pkg::ACT_INSERT
                                                      : ssip_pkg::ACT_POP;
        if (pick < 35)
            rq.key = $urandom_range(15);
        else if (pick < 45)
        begin
            case ($urandom_range(3))
                0:       rq.key = '0;
                1:       rq.key = '1;
                2:       rq.key = 32'h7FFF_FFFF;
                default: rq.key = 32'h8000_0000;
            endcase
        end
        else
            rq.key = $urandom();
        return rq;
    endfunction

    task automatic load_directed;
        req_q.push_back(make_request(ssip_pkg::ACT_POP, 32'h0));
        req_q.push_back(make_request(ssip_pkg::ACT_INSERT, 32'h0));
        req_q.push_back(make_request(ssip_pkg::ACT_INSERT, 32'hFFFF_FFFF));
        req_q.push_back(make_request(ssip_pkg::ACT_INSERT, 32'h0));
        req_q.push_back(make_request(ssip_pkg::ACT_INSERT, 32'h8000_0000));
        req_q.push_back(make_request(ssip_pkg::ACT_INSERT, 32'h0000_0001));
        req_q.push_back(make_request(ssip_pkg::ACT_INSERT, 32'hFFFF_FFFE));
        for (int k = 1; k <= 11; k++)
            req_q.push_back(make_request(ssip_pkg::ACT_INSERT, 32'h1111_1111 * 32'(k)));
        // store is full now: a new key, then a key already held
        req_q.push_back(make_request(ssip_pkg::ACT_INSERT, 32'h5555_5554));
        req_q.push_back(make_request(ssip_pkg::ACT_INSERT, 32'h8000_0000));
        req_q.push_back(make_request(ssip_pkg::ACT_POP, 32'hFFFF_FFFF));
        for (int k = 0; k < 3; k++)
            req_q.push_back(make_request(ssip_pkg::ACT_POP, 32'h0));
    endtask

    task automatic load_random(input int n_items);
        int insert_pct;
        insert_pct = 80;
        for (int i = 0; i < n_items; i++)
        begin
            // swing between filling and draining so full and empty both get hit
            if (i % 40 == 0)
                insert_pct = $urandom_range(1) ? 80 : 30;
            req_q.push_back(random_request(insert_pct));
        end
    endtask

    task automatic drive_queue;
        bit holding;
        holding = 1'b0;
        while (req_q.size() > 0 || holding)
        begin
            @(posedge clk);
            if (holding && !in_stall)
                holding = 1'b0;
            if (!holding)
            begin
                if (req_q.size() > 0 && $urandom_range(99) >= gap_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= req_q[0];
                    req_q.delete(0);
                    holding  = 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    endtask

    task automatic wait_idle;
        do
            @(posedge clk);
        while (in_valid || pending != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_order(input logic descending);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_data  <= descending;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        logic order_plan [4];
        int   gap_plan   [4];
        int   stall_plan [4];
        order_plan = '{1'b1, 1'b0, 1'b1, 1'b0};
        gap_plan   = '{0, 50, 0, 11};
        stall_plan = '{0, 0, 50, 11};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        write_order(1'b0);
        load_directed();
        drive_queue();

        // first switch happens with keys still held, so they stay unsorted
        for (int p = 0; p < 4; p++)
        begin
            write_order(order_plan[p]);
            gap_pct   = gap_plan[p];
            stall_pct = stall_plan[p];
            load_random(250);
            drive_queue();
        end

        wait_idle();
        stall_pct = 0;
        repeat (4) @(posedge clk);

        $display("checked %0d responses across ascending, descending and reordered stores",
            checked);
        $display("outcomes seen: %0d duplicate, %0d full, %0d underflow",
            dup_seen, full_seen, underflow_seen);
        if (mismatches == 0)
            $display("sorted_set_insert_pop verification clean");
        else
            $display("sorted_set_insert_pop verification failed");
        $finish;
    end

endmodule
